// ===== hdl/bfa_pkg.sv =====
// Package: item types and fixed field widths of the best-fit block allocator.
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int unsigned FUNC_W  = 1;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD    = 1'b0,
		FUNC_REQUEST = 1'b1
	} func_t;

	typedef struct packed {
		func_t               func;
		logic [SLOT_W-1:0]   block_slot;
		logic [VALUE_W-1:0]  size_value;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [SLOT_W-1:0]   chosen_block;
		logic [VALUE_W-1:0]  slack;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  block_count;
	} cfg_item_t;

endpackage

// ===== hdl/bfa_stream_if.sv =====
// Interface: valid/ready channel carrying one typed payload.
`timescale 1ns / 1ps

interface bfa_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/best_fit_block_allocator.sv =====
// Top level: best-fit block allocator with block sizes held in a RAM.
//
//  channel  dir  payload                            handshake
//  req      in   func, block_slot, size_value       valid / ready
//  res      out  found, chosen_block, slack         valid / ready
//  cfg      in   block_count                        valid / ready (always ready)
//
// A load gives no result. A request reads size RAM entries 0 to limit - 1,
// limit being block_count saturated to NUM_BLOCKS: the size RAM is read one entry
// a cycle, the compare runs in the cycle after each read, then S_FIN grants.
// Reset clears all used marks at once; sizes are undefined until loaded.
// A waiting result does not block loads; a request finishing while it waits
// holds in the grant state until the output register is free.
`timescale 1ns / 1ps

module best_fit_block_allocator #(
	parameter int unsigned NUM_BLOCKS = 16,
	parameter int unsigned SIZE_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	bfa_stream_if.sink   req,
	bfa_stream_if.source res,
	bfa_stream_if.sink   cfg
);
	import bfa_pkg::*;

	localparam int unsigned IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int unsigned CNT_W  = ($clog2(NUM_BLOCKS + 1) > COUNT_W) ?
	                                 $clog2(NUM_BLOCKS + 1) : COUNT_W;
	localparam int unsigned SZX_W  = (SIZE_BITS > VALUE_W) ? SIZE_BITS : VALUE_W;
	localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_BLOCKS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t                 state_q;
	logic [COUNT_W-1:0]     block_count_q;
	logic [NUM_BLOCKS-1:0]  used_q;
	logic                   res_valid_q;
	out_item_t              res_q;

	logic [CNT_W-1:0]       limit_q;
	logic [CNT_W-1:0]       rd_idx_q;
	logic [SIZE_BITS-1:0]   size_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   have_q;
	logic [SIZE_BITS-1:0]   best_slack_q;
	logic [IDX_W-1:0]       best_idx_q;

	in_item_t               item;
	logic                   req_acc;
	logic [CNT_W-1:0]       slot_ext;
	logic                   slot_ok;
	logic [SZX_W-1:0]       size_ext;
	logic [SIZE_BITS-1:0]   size_in;
	logic [CNT_W-1:0]       count_ext;
	logic [CNT_W-1:0]       limit_in;
	logic                   ram_we;
	logic [SIZE_BITS-1:0]   rd_data;
	logic                   fits;
	logic [SIZE_BITS-1:0]   diff;
	logic                   take;
	logic                   out_free;
	logic [SZX_W-1:0]       slack_ext;
	logic [CNT_W-1:0]       idx_ext;

	assign item      = req.data;
	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign slot_ext  = CNT_W'(item.block_slot);
	assign slot_ok   = (slot_ext < NUM_C);
	assign size_ext  = SZX_W'(item.size_value);
	assign size_in   = size_ext[SIZE_BITS-1:0];
	assign count_ext = CNT_W'(block_count_q);
	assign limit_in  = (count_ext > NUM_C) ? NUM_C : count_ext;
	assign ram_we    = req_acc && (item.func == FUNC_LOAD) && slot_ok;

	bfa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_sizes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_ext[IDX_W-1:0]),
		.wdata (size_in),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// compare runs in the cycle after the read
	assign fits = !used_q[idx_s1] && (rd_data >= size_q);
	assign diff = rd_data - size_q;
	assign take = vld_s1 && fits && (!have_q || (diff < best_slack_q));

	assign out_free  = !res_valid_q || res.ready;
	assign slack_ext = SZX_W'(best_slack_q);
	assign idx_ext   = CNT_W'(best_idx_q);

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			block_count_q <= cfg.data.block_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			res_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			if (res_valid_q && res.ready && (state_q != S_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ram_we) begin
						used_q[slot_ext[IDX_W-1:0]] <= 1'b0;
					end
					if (req_acc && (item.func == FUNC_REQUEST)) begin
						state_q <= (limit_in == '0) ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_idx_q == limit_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						res_valid_q        <= 1'b1;
						res_q.found        <= have_q;
						res_q.chosen_block <= have_q ? idx_ext[SLOT_W-1:0] : '0;
						res_q.slack        <= have_q ? slack_ext[VALUE_W-1:0] : '0;
						if (have_q) begin
							used_q[best_idx_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (req_acc) begin
			limit_q  <= limit_in;
			size_q   <= size_in;
			rd_idx_q <= '0;
			have_q   <= 1'b0;
		end else begin
			if (state_q == S_SCAN) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (take) begin
				have_q       <= 1'b1;
				best_slack_q <= diff;
				best_idx_q   <= idx_s1;
			end
		end
	end
endmodule

// ===== hdl/bfa_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module bfa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/bfa_checker.sv =====
// Checker: port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps

module bfa_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_func,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_found,
	input logic [3:0]  res_block,
	input logic [15:0] res_slack
);
	import bfa_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_block)
		&& $stable(res_slack) && $stable(res_found))
		else $error("result changed while stalled");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_block == '0 && res_slack == '0)
		else $error("not-found result carries index or slack");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_REQUEST |=> !req_ready)
		else $error("request accepted without a scan");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_LOAD |=> req_ready)
		else $error("load left the block busy");

	a_grant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready))
		else $error("result raised outside a request");
endmodule

bind best_fit_block_allocator bfa_port_checker u_bfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_func  (req.data.func),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_found (res.data.found),
	.res_block (res.data.chosen_block),
	.res_slack (res.data.slack)
);

// ===== verif/bfa_checker.sv =====
// Checker: watches the allocator channels, predicts each grant and compares it.
`timescale 1ns / 1ps

module bfa_checker
	import bfa_pkg::*;
#(
	parameter int unsigned NUM_BLOCKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bfa_stream_if       req_mon,
	bfa_stream_if       res_mon,
	bfa_stream_if       cfg_mon,
	output int unsigned grants_due,
	output int unsigned mismatch_count
);

	logic [VALUE_W-1:0]    block_size [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] block_taken;
	logic [COUNT_W-1:0]    active_blocks;
	out_item_t             grant_q [$];

	assign grants_due = grant_q.size();

	// Smallest non-negative slack among free blocks in range; lowest index wins ties.
	function automatic out_item_t best_fit(input logic [VALUE_W-1:0] want);
		out_item_t          pick;
		int unsigned        span;
		logic [VALUE_W-1:0] spare;
		pick = '0;
		span = (active_blocks > NUM_BLOCKS) ? NUM_BLOCKS : active_blocks;
		for (int unsigned i = 0; i < span; i++) begin
			if (!block_taken[i] && block_size[i] >= want) begin
				spare = block_size[i] - want;
				if (!pick.found || spare < pick.slack) begin
					pick.found        = 1'b1;
					pick.slack        = spare;
					pick.chosen_block = i[SLOT_W-1:0];
				end
			end
		end
		return pick;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t   got;
		out_item_t   want;
		int unsigned faults;
		if (!arst_n) begin
			block_taken    <= '0;
			active_blocks  <= '0;
			mismatch_count <= 0;
			grant_q.delete();
		end else begin
			faults = 0;
			if (res_mon.valid && res_mon.ready) begin
				got = res_mon.data;
				if (grant_q.size() == 0) begin
					$error("grant with no request outstanding: found %0d block %0d slack %0d",
						got.found, got.chosen_block, got.slack);
					faults++;
				end else begin
					want = grant_q.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, got.found);
						faults++;
					end
					if (got.chosen_block !== want.chosen_block) begin
						$error("chosen_block: expected %0d, got %0d",
							want.chosen_block, got.chosen_block);
						faults++;
					end
					if (got.slack !== want.slack) begin
						$error("slack: expected %0d, got %0d", want.slack, got.slack);
						faults++;
					end
				end
			end
			if (cfg_mon.valid && cfg_mon.ready)
				active_blocks <= cfg_mon.data.block_count;
			if (req_mon.valid && req_mon.ready) begin
				if (req_mon.data.func == FUNC_LOAD) begin
					block_size[req_mon.data.block_slot]  <= req_mon.data.size_value;
					block_taken[req_mon.data.block_slot] <= 1'b0;
				end else begin
					want = best_fit(req_mon.data.size_value);
					if (want.found)
						block_taken[want.chosen_block] <= 1'b1;
					grant_q.push_back(want);
				end
			end
			mismatch_count <= mismatch_count + faults;
		end
	end

endmodule

// ===== verif/best_fit_block_allocator_tb.sv =====
// Testbench top: drives loads, allocation requests and block counts into the allocator.
`timescale 1ns / 1ps

module best_fit_block_allocator_tb;
	import bfa_pkg::*;

	localparam int unsigned NUM_BLOCKS   = 16;
	localparam int unsigned SETTLE       = NUM_BLOCKS + 8;
	localparam int unsigned PHASES       = 12;
	localparam int unsigned PHASE_ITEMS  = 106;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned LIMIT_CYCLES = 1000000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned items_offered = 0;
	int unsigned grants_due;
	int unsigned mismatch_count;
	bit          quiet_gaps = 1'b0;
	bit          hold_results = 1'b0;
	logic [VALUE_W-1:0] loaded_size [NUM_BLOCKS];

	bfa_stream_if #(.T(in_item_t))  req_ch ();
	bfa_stream_if #(.T(out_item_t)) res_ch ();
	bfa_stream_if #(.T(cfg_item_t)) cfg_ch ();

	best_fit_block_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (VALUE_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	bfa_checker #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_mon       (req_ch),
		.res_mon       (res_ch),
		.cfg_mon       (cfg_ch),
		.grants_due    (grants_due),
		.mismatch_count(mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("best_fit_block_allocator test failed");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one; none at all in a quiet phase.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_block_size();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return VALUE_W'($urandom_range(0, 16'hFFFF));
		if (r < 7)
			return VALUE_W'($urandom_range(0, 31));
		if (r < 9)
			return VALUE_W'(1000 + $urandom_range(0, 3));
		return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
	endfunction

	// Aim near a loaded size so that exact fits and ties come up often.
	function automatic logic [VALUE_W-1:0] pick_request_size();
		int unsigned        r;
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] trim;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			base = loaded_size[$urandom_range(0, NUM_BLOCKS - 1)];
			trim = VALUE_W'($urandom_range(0, 3));
			return (base > trim) ? base - trim : '0;
		end
		if (r < 6)
			return '0;
		if (r < 8)
			return VALUE_W'($urandom_range(0, 16'hFFFF));
		return VALUE_W'($urandom_range(0, 40));
	endfunction

	task automatic offer(input in_item_t item);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_offered++;
	endtask

	task automatic load_block(input int unsigned slot, input logic [VALUE_W-1:0] size);
		loaded_size[slot] = size;
		offer('{func: FUNC_LOAD, block_slot: slot[SLOT_W-1:0], size_value: size});
	endtask

	task automatic request_block(input logic [VALUE_W-1:0] size);
		offer('{func: FUNC_REQUEST, block_slot: SLOT_W'($urandom_range(0, 15)), size_value: size});
	endtask

	// Sample the outstanding count away from the clock edge, then let the last load settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (grants_due != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_block_count(input int unsigned count);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{block_count: COUNT_W'(count)};
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : result_sink
		int unsigned gap;
		res_ch.ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_results) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			gap = pick_gap();
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin : stimulus
		logic [VALUE_W-1:0] opening [NUM_BLOCKS];
		int unsigned        count;
		int unsigned        span;
		int unsigned        phase_end;
		int unsigned        pick;
		int unsigned        slot;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		opening = '{16'hFFFF, 16'h0000, 16'd100, 16'd100, 16'hAAAA, 16'h5555, 16'd1, 16'd2,
			16'd3, 16'd500, 16'd501, 16'd1000, 16'd1000, 16'd30000, 16'd7, 16'hFFFE};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no blocks in range every request misses.
		set_block_count(0);
		request_block(16'h0000);
		request_block(16'hFFFF);
		for (int unsigned i = 0; i < NUM_BLOCKS; i++)
			load_block(i, opening[i]);

		// Exact-fit tie, zero request, full-scale request, then exhaustion.
		set_block_count(NUM_BLOCKS);
		request_block(16'd100);
		request_block(16'd100);
		request_block(16'h0000);
		request_block(16'hFFFF);
		request_block(16'hFFFF);
		// Rewrite a taken block to free it again.
		load_block(0, 16'hFFFF);
		request_block(16'hFFFF);

		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p)
				0: count = 31;
				1: count = 1;
				2: count = 17;
				3: count = NUM_BLOCKS;
				4: count = 0;
				default: count = $urandom_range(0, 31);
			endcase
			span = (count > NUM_BLOCKS) ? NUM_BLOCKS : count;
			quiet_gaps = (p == 1) || ($urandom_range(0, 3) == 0);
			set_block_count(count);
			if (p == 2)
				hold_results = 1'b1;
			phase_end = items_offered + PHASE_ITEMS;
			while (items_offered < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					// Refill a few blocks, then allocate against them.
					repeat ($urandom_range(1, 6)) begin
						if (span != 0 && $urandom_range(0, 3) != 0)
							slot = $urandom_range(0, span - 1);
						else
							slot = $urandom_range(0, NUM_BLOCKS - 1);
						load_block(slot, pick_block_size());
					end
					repeat ($urandom_range(1, 4))
						request_block(pick_request_size());
				end else if (pick < 8) begin
					request_block(VALUE_W'($urandom_range(0, 16'hFFFF)));
				end else begin
					load_block($urandom_range(0, NUM_BLOCKS - 1),
						VALUE_W'($urandom_range(0, 16'hFFFF)));
				end
			end
		end

		drain();
		@(negedge clk);
		if (mismatch_count == 0)
			$display("best_fit_block_allocator test passed");
		else
			$display("best_fit_block_allocator test failed");
		$finish;
	end

endmodule
